FILE: rtl/mexp_pkg.sv
package mexp_pkg;

   localparam int MOD_W  = 16;
   localparam int BASE_W = 31;
   localparam int EXP_W  = 32;
   localparam int PROD_W = 2 * MOD_W;

   // restoring remainder: one dividend bit per cycle
   localparam int DIV_STEPS = PROD_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   localparam logic [MOD_W-1:0] MOD_RESET = 16'd97;
   localparam logic [MOD_W-1:0] MOD_ONE   = 16'd1;

   typedef logic [MOD_W-1:0]  mod_type;
   typedef logic [PROD_W-1:0] prod_type;

endpackage

FILE: rtl/modular_exponentiation.sv
// Channel   Direction  Ports                                   Beat taken when
// request   in         req_start, req_base_value, req_exponent req_start & !busy
// response  out        rsp_valid, rsp_residue                  rsp_valid (one cycle)
// csr       in         csr_valid, csr_ready, csr_data          csr_valid & csr_ready
//
// One remainder unit (1 bit/cycle) behind one 16x16 multiplier.
// Squarings stop once no set exponent bit is left.
// Synchronous active-high reset; modulus returns to 97.
// busy is high while an item is in work; the response cannot be stalled.
module modular_exponentiation #(
   parameter int EXP_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_start,
   input  logic [mexp_pkg::BASE_W-1:0]      req_base_value,
   input  logic [mexp_pkg::EXP_W-1:0]       req_exponent,
   output logic                             busy,
   output logic                             rsp_valid,
   output logic [mexp_pkg::MOD_W-1:0]       rsp_residue,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mexp_pkg::MOD_W-1:0]       csr_data
);

   // bits beyond the exponent field are ignored and never touch the accumulator
   localparam int SCAN   = (EXP_BITS < mexp_pkg::EXP_W) ? EXP_BITS : mexp_pkg::EXP_W;
   localparam int LEFT_W = $clog2(SCAN + 1);

   typedef enum logic [1:0] {IDLE, DIV, CHECK} state_type;
   typedef enum logic [1:0] {T_BASE, T_ACC, T_SQR} target_type;

   state_type                      state_ff, state_in;
   target_type                     target_ff, target_in;
   mexp_pkg::mod_type              modulus_ff, modulus_in;
   mexp_pkg::mod_type              base_ff, base_in;
   mexp_pkg::mod_type              acc_ff, acc_in;
   mexp_pkg::mod_type              rem_ff, rem_in;
   mexp_pkg::mod_type              residue_ff, residue_in;
   mexp_pkg::prod_type             div_ff, div_in;
   logic [mexp_pkg::EXP_W-1:0]     exp_ff, exp_in;
   logic [LEFT_W-1:0]              left_ff, left_in;
   logic [mexp_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   logic                           use_acc;
   mexp_pkg::prod_type             product;
   logic [mexp_pkg::MOD_W:0]       trial;
   logic [mexp_pkg::MOD_W:0]       mod_ext;
   mexp_pkg::mod_type              rem_step;

   assign use_acc = (target_ff != T_ACC) && exp_ff[0];
   assign product = mexp_pkg::PROD_W'(use_acc ? acc_ff : base_ff)
                  * mexp_pkg::PROD_W'(base_ff);

   assign trial   = {rem_ff, div_ff[mexp_pkg::PROD_W-1]};
   assign mod_ext = {1'b0, modulus_ff};
   assign rem_step = (trial >= mod_ext) ? mexp_pkg::MOD_W'(trial - mod_ext)
                                        : mexp_pkg::MOD_W'(trial);

   always_comb begin
      state_in     = state_ff;
      target_in    = target_ff;
      modulus_in   = modulus_ff;
      base_in      = base_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      residue_in   = residue_ff;
      div_in       = div_ff;
      exp_in       = exp_ff;
      left_in      = left_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;

      if (csr_valid) begin
         modulus_in = (csr_data == '0) ? mexp_pkg::MOD_ONE : csr_data;
      end

      case (state_ff)
         IDLE: begin
            if (req_start) begin
               div_in    = {1'b0, req_base_value};
               exp_in    = req_exponent;
               left_in   = LEFT_W'(SCAN);
               acc_in    = mexp_pkg::MOD_ONE;
               target_in = T_BASE;
               rem_in    = '0;
               cnt_in    = '0;
               state_in  = DIV;
            end
         end
         DIV: begin
            rem_in = rem_step;
            div_in = {div_ff[mexp_pkg::PROD_W-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == mexp_pkg::CNT_W'(mexp_pkg::DIV_STEPS - 1)) begin
               state_in = CHECK;
               case (target_ff)
                  T_ACC:   acc_in = rem_step;
                  T_SQR: begin
                     base_in = rem_step;
                     exp_in  = exp_ff >> 1;
                     left_in = left_ff - 1'b1;
                  end
                  default: base_in = rem_step;
               endcase
            end
         end
         CHECK: begin
            rem_in = '0;
            cnt_in = '0;
            div_in = product;
            if (target_ff == T_ACC) begin
               target_in = T_SQR;
               state_in  = DIV;
            end else if (left_ff == '0 || exp_ff == '0) begin
               residue_in   = acc_ff;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end else begin
               target_in = use_acc ? T_ACC : T_SQR;
               state_in  = DIV;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         modulus_ff   <= mexp_pkg::MOD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         modulus_ff   <= modulus_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      target_ff  <= target_in;
      base_ff    <= base_in;
      acc_ff     <= acc_in;
      rem_ff     <= rem_in;
      residue_ff <= residue_in;
      div_ff     <= div_in;
      exp_ff     <= exp_in;
      left_ff    <= left_in;
      cnt_ff     <= cnt_in;
   end

   assign busy        = (state_ff != IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_residue = residue_ff;
   assign csr_ready   = 1'b1;

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("response strobe held");

   a_strobe_from_check: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == CHECK))
      else $error("response without final check");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (req_start && !busy) |=> busy)
      else $error("accepted beat did not start work");

   a_modulus_nonzero: assert property (@(posedge clock) disable iff (reset)
      modulus_ff != '0)
      else $error("modulus zero");

   a_rem_below_mod: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DIV && !$past(csr_valid)) |-> rem_ff < modulus_ff)
      else $error("partial remainder out of range");

endmodule
